[src/rsi_pkg.sv]
// Shared widths and the beat formats that travel down the square-root and divider cell rows.
// No dependencies. Every other file in src imports this package.
`default_nettype none
package rsi_pkg;

    localparam int COORD_W   = 16;
    localparam int RAD_W     = COORD_W - 1;
    localparam int FRAC_BITS = 8;

    // Widths of the quadratic terms for COORD_W-bit inputs.
    localparam int OFS_W   = COORD_W + 1;          // origin - center
    localparam int A_W     = 2 * COORD_W;          // a = D.D
    localparam int H_W     = 2 * COORD_W + 3;      // h = O.D, signed
    localparam int C_W     = 2 * COORD_W + 3;      // c = O.O - R*R, signed
    localparam int HM_W    = 2 * COORD_W + 2;      // magnitude of h
    localparam int HALF_W  = HM_W / 2;             // split of h and c for the squares
    localparam int AH_W    = A_W / 2;
    localparam int PROD_W  = 2 * HM_W;             // h*h and a*c
    localparam int DISC_W  = 2 * HM_W - 2;         // discriminant on a hit
    localparam int ROOT_W  = DISC_W / 2;
    localparam int SQ_REM_W = ROOT_W + 3;
    localparam int SQRT_CELLS = ROOT_W;
    localparam int NUM_W   = HM_W + FRAC_BITS;
    localparam int Q_W     = 32;
    localparam int DIV_CELLS = Q_W;

    typedef struct packed {
        logic                valid;
        logic                hit;
        logic [HM_W-1:0]     hm;
        logic [A_W-1:0]      a;
        logic [DISC_W-1:0]   rad;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } sq_t;

    typedef struct packed {
        logic           valid;
        logic           hit;
        logic           sat;
        logic [A_W-1:0] a;
        logic [A_W-1:0] rem;
        logic [Q_W-1:0] num;
        logic [Q_W-1:0] q;
    } dv_t;

endpackage
`default_nettype wire

[src/rsi_front.sv]
// Front end: offsets, products, dot-product sums and the discriminant, five registered stages.
// Depends on rsi_pkg. Feeds the first square-root cell.
`default_nettype none
module rsi_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [rsi_pkg::COORD_W-1:0] origin_x,
    input  wire logic [rsi_pkg::COORD_W-1:0] origin_y,
    input  wire logic [rsi_pkg::COORD_W-1:0] origin_z,
    input  wire logic [rsi_pkg::COORD_W-1:0] dir_x,
    input  wire logic [rsi_pkg::COORD_W-1:0] dir_y,
    input  wire logic [rsi_pkg::COORD_W-1:0] dir_z,
    input  wire logic [rsi_pkg::COORD_W-1:0] center_x,
    input  wire logic [rsi_pkg::COORD_W-1:0] center_y,
    input  wire logic [rsi_pkg::COORD_W-1:0] center_z,
    input  wire logic [rsi_pkg::RAD_W-1:0]   sphere_radius,
    output rsi_pkg::sq_t                     sq_out
);
    import rsi_pkg::*;

    logic [4:0] v_reg;

    logic signed [OFS_W-1:0]   o_reg [3];
    logic signed [COORD_W-1:0] d_reg [3];
    logic [RAD_W-1:0]          r_reg;

    logic signed [2*OFS_W-1:0]           od_reg [3];
    logic signed [2*COORD_W-1:0]         dd_reg [3];
    logic signed [2*OFS_W-1:0]           oo_reg [3];
    logic [2*RAD_W-1:0]                  rr_reg;

    logic [A_W-1:0]        a3_reg;
    logic signed [H_W-1:0] h3_reg;
    logic signed [C_W-1:0] c3_reg;

    logic                  pre_reg;
    logic [HM_W-1:0]       hm4_reg;
    logic [A_W-1:0]        a4_reg;
    logic [2*HALF_W-1:0]   hh2_reg, hhl_reg, hl2_reg;
    logic [AH_W+HALF_W-1:0] ahch_reg, ahcl_reg, alch_reg, alcl_reg;

    logic                  hit5_reg;
    logic [HM_W-1:0]       hm5_reg;
    logic [A_W-1:0]        a5_reg;
    logic [DISC_W-1:0]     disc5_reg;

    logic [A_W-1:0]        a_sum;
    logic signed [H_W-1:0] h_sum;
    logic signed [C_W-1:0] c_sum;
    logic [C_W-1:0]        oo_sum;
    logic [H_W-1:0]        h_neg;
    logic [C_W-1:0]        c_mag;
    logic                  pre_hit;
    logic [PROD_W-1:0]     hsq, acp;

    always_comb
    begin
        a_sum  = A_W'(dd_reg[0]) + A_W'(dd_reg[1]) + A_W'(dd_reg[2]);
        h_sum  = H_W'(od_reg[0]) + H_W'(od_reg[1]) + H_W'(od_reg[2]);
        oo_sum = C_W'(oo_reg[0]) + C_W'(oo_reg[1]) + C_W'(oo_reg[2]);
        c_sum  = $signed(oo_sum - C_W'(rr_reg));
        h_neg  = H_W'(-h3_reg);
        c_mag  = C_W'(c3_reg);
        pre_hit = (a3_reg != '0) && h3_reg[H_W-1] && !c3_reg[C_W-1] && (c3_reg != '0);
        hsq = (PROD_W'(hh2_reg) << (2 * HALF_W)) + (PROD_W'(hhl_reg) << (HALF_W + 1))
            + PROD_W'(hl2_reg);
        acp = (PROD_W'(ahch_reg) << (AH_W + HALF_W)) + (PROD_W'(ahcl_reg) << AH_W)
            + (PROD_W'(alch_reg) << HALF_W) + PROD_W'(alcl_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg[0] <= OFS_W'($signed(origin_x)) - OFS_W'($signed(center_x));
            o_reg[1] <= OFS_W'($signed(origin_y)) - OFS_W'($signed(center_y));
            o_reg[2] <= OFS_W'($signed(origin_z)) - OFS_W'($signed(center_z));
            d_reg[0] <= $signed(dir_x);
            d_reg[1] <= $signed(dir_y);
            d_reg[2] <= $signed(dir_z);
            r_reg    <= sphere_radius;

            for (int i = 0; i < 3; i++)
            begin
                od_reg[i] <= o_reg[i] * OFS_W'(d_reg[i]);
                dd_reg[i] <= d_reg[i] * d_reg[i];
                oo_reg[i] <= o_reg[i] * o_reg[i];
            end
            rr_reg <= r_reg * r_reg;

            a3_reg <= a_sum;
            h3_reg <= h_sum;
            c3_reg <= c_sum;

            // Magnitudes are only meaningful on a candidate hit (h < 0, c > 0).
            pre_reg  <= pre_hit;
            hm4_reg  <= h_neg[HM_W-1:0];
            a4_reg   <= a3_reg;
            hh2_reg  <= h_neg[HM_W-1:HALF_W] * h_neg[HM_W-1:HALF_W];
            hhl_reg  <= h_neg[HM_W-1:HALF_W] * h_neg[HALF_W-1:0];
            hl2_reg  <= h_neg[HALF_W-1:0] * h_neg[HALF_W-1:0];
            ahch_reg <= a3_reg[A_W-1:AH_W] * c_mag[HM_W-1:HALF_W];
            ahcl_reg <= a3_reg[A_W-1:AH_W] * c_mag[HALF_W-1:0];
            alch_reg <= a3_reg[AH_W-1:0] * c_mag[HM_W-1:HALF_W];
            alcl_reg <= a3_reg[AH_W-1:0] * c_mag[HALF_W-1:0];

            hit5_reg  <= pre_reg && (hsq > acp);
            hm5_reg   <= hm4_reg;
            a5_reg    <= a4_reg;
            disc5_reg <= DISC_W'(hsq - acp);
        end
    end

    always_comb
    begin
        sq_out.valid = v_reg[4];
        sq_out.hit   = hit5_reg;
        sq_out.hm    = hm5_reg;
        sq_out.a     = a5_reg;
        sq_out.rad   = disc5_reg;
        sq_out.rem   = '0;
        sq_out.root  = '0;
    end

endmodule
`default_nettype wire

[src/rsi_sqrt_cell.sv]
// One cell of the square-root row: brings down two radicand bits and settles one root bit.
// Depends on rsi_pkg.
`default_nettype none
module rsi_sqrt_cell (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire rsi_pkg::sq_t cur,
    output rsi_pkg::sq_t nxt
);
    import rsi_pkg::*;

    sq_t                 stage_reg;
    logic                valid_reg;
    logic [SQ_REM_W-1:0] rem_t, trial;
    logic                ge;
    sq_t                 stage_next;

    always_comb
    begin
        rem_t = {cur.rem[SQ_REM_W-3:0], cur.rad[DISC_W-1 -: 2]};
        trial = {1'b0, cur.root, 2'b01};
        ge    = rem_t >= trial;
        stage_next       = cur;
        stage_next.rem   = ge ? (rem_t - trial) : rem_t;
        stage_next.root  = {cur.root[ROOT_W-2:0], ge};
        stage_next.rad   = {cur.rad[DISC_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= cur.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        nxt       = stage_reg;
        nxt.valid = valid_reg;
    end

endmodule
`default_nettype wire

[src/rsi_div_cell.sv]
// One cell of the restoring divider row: shifts in one numerator bit and settles one quotient bit.
// Depends on rsi_pkg.
`default_nettype none
module rsi_div_cell (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire rsi_pkg::dv_t cur,
    output rsi_pkg::dv_t nxt
);
    import rsi_pkg::*;

    dv_t          stage_reg;
    logic         valid_reg;
    logic [A_W:0] rem_t, sub;
    logic         ge;
    dv_t          stage_next;

    always_comb
    begin
        rem_t = {cur.rem, cur.num[Q_W-1]};
        sub   = rem_t - {1'b0, cur.a};
        ge    = rem_t >= {1'b0, cur.a};
        stage_next     = cur;
        stage_next.rem = ge ? sub[A_W-1:0] : rem_t[A_W-1:0];
        stage_next.num = {cur.num[Q_W-2:0], 1'b0};
        stage_next.q   = {cur.q[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= cur.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        nxt       = stage_reg;
        nxt.valid = valid_reg;
    end

endmodule
`default_nettype wire

[src/ray_sphere_intersect_unit.sv]
// Top level of the ray-sphere intersection unit: front end, square-root row, divider row.
// Depends on rsi_pkg, rsi_front, rsi_sqrt_cell and rsi_div_cell.
//
//   channel | valid     | stall     | payload
//   ray     | ray_valid | ray_stall | origin_*, dir_*, center_*, sphere_radius
//   result  | res_valid | res_stall | hit, distance
//
// One beat enters per cycle unless ray_stall is up; each beat passes 5 front stages,
// 33 square-root cells, 1 numerator stage, 32 divider cells and 1 output register.
// The whole pipeline advances together; it holds while a result beat sits stalled,
// and ray_stall is raised in exactly those cycles.
// Reset clears only the valid bits.
`default_nettype none
module ray_sphere_intersect_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        ray_valid,
    output logic                             ray_stall,
    input  wire logic [rsi_pkg::COORD_W-1:0] origin_x,
    input  wire logic [rsi_pkg::COORD_W-1:0] origin_y,
    input  wire logic [rsi_pkg::COORD_W-1:0] origin_z,
    input  wire logic [rsi_pkg::COORD_W-1:0] dir_x,
    input  wire logic [rsi_pkg::COORD_W-1:0] dir_y,
    input  wire logic [rsi_pkg::COORD_W-1:0] dir_z,
    input  wire logic [rsi_pkg::COORD_W-1:0] center_x,
    input  wire logic [rsi_pkg::COORD_W-1:0] center_y,
    input  wire logic [rsi_pkg::COORD_W-1:0] center_z,
    input  wire logic [rsi_pkg::RAD_W-1:0]   sphere_radius,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output logic                             hit,
    output logic [rsi_pkg::Q_W-1:0]          distance
);
    import rsi_pkg::*;

    logic en;
    sq_t  sq_pipe [SQRT_CELLS+1];
    dv_t  dv_pipe [DIV_CELLS+1];

    logic             prep_valid_reg;
    dv_t              prep_reg;
    logic [HM_W-1:0]  diff;
    logic [NUM_W-1:0] num;
    dv_t              prep_next;

    logic             res_valid_reg;
    logic             hit_reg;
    logic [Q_W-1:0]   distance_reg;

    assign en        = !(res_valid_reg && res_stall);
    assign ray_stall = !en;

    rsi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (ray_valid),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .origin_z      (origin_z),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .sphere_radius (sphere_radius),
        .sq_out        (sq_pipe[0])
    );

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        rsi_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .cur   (sq_pipe[i]),
            .nxt   (sq_pipe[i+1])
        );
    end

    // Numerator (-h - s) scaled by the fraction bits; a quotient of 2^32 or more saturates.
    always_comb
    begin
        diff = sq_pipe[SQRT_CELLS].hm - HM_W'(sq_pipe[SQRT_CELLS].root);
        num  = {diff, FRAC_BITS'(0)};
        prep_next.valid = 1'b0;
        prep_next.hit   = sq_pipe[SQRT_CELLS].hit;
        prep_next.sat   = A_W'(num[NUM_W-1:Q_W]) >= sq_pipe[SQRT_CELLS].a;
        prep_next.a     = sq_pipe[SQRT_CELLS].a;
        prep_next.rem   = A_W'(num[NUM_W-1:Q_W]);
        prep_next.num   = num[Q_W-1:0];
        prep_next.q     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= sq_pipe[SQRT_CELLS].valid;
            res_valid_reg  <= dv_pipe[DIV_CELLS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg     <= prep_next;
            hit_reg      <= dv_pipe[DIV_CELLS].hit;
            distance_reg <= !dv_pipe[DIV_CELLS].hit ? '0 :
                            dv_pipe[DIV_CELLS].sat ? '1 : dv_pipe[DIV_CELLS].q;
        end
    end

    always_comb
    begin
        dv_pipe[0]       = prep_reg;
        dv_pipe[0].valid = prep_valid_reg;
    end

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        rsi_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .cur   (dv_pipe[j]),
            .nxt   (dv_pipe[j+1])
        );
    end

    assign res_valid = res_valid_reg;
    assign hit       = hit_reg;
    assign distance  = distance_reg;

    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !hit |-> distance == '0)
        else $error("miss beat carries a nonzero distance");

    a_hold_tail : assert property (@(posedge clk) disable iff (!rst_n)
        !en && dv_pipe[DIV_CELLS].valid |=> dv_pipe[DIV_CELLS].valid)
        else $error("divider tail beat lost during a stall");

    a_sqrt_root_hit : assert property (@(posedge clk) disable iff (!rst_n)
        sq_pipe[SQRT_CELLS].valid && sq_pipe[SQRT_CELLS].hit
        |-> HM_W'(sq_pipe[SQRT_CELLS].root) < sq_pipe[SQRT_CELLS].hm)
        else $error("square root not below |h| on a hit");

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        ray_stall |-> res_valid)
        else $error("input stalled with no result waiting");

endmodule
`default_nettype wire

[sim/ray_sphere_intersect_unit_tb.sv]
// Testbench for ray_sphere_intersect_unit: directed and random ray/sphere beats, scoreboarded
// against an integer model of the quadratic test. Depends on rsi_pkg and the RTL in src.
`timescale 1ns / 100ps
`default_nettype none
module ray_sphere_intersect_unit_tb;
    import rsi_pkg::*;

    localparam int LATENCY     = 72;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [COORD_W-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
        logic [RAD_W-1:0]   r;
    } ray_t;

    typedef struct {
        logic           hit;
        logic [Q_W-1:0] t_near;
    } isect_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic ray_valid = 1'b0;
    logic ray_stall;
    logic [COORD_W-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic [COORD_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic [COORD_W-1:0] center_x = '0, center_y = '0, center_z = '0;
    logic [RAD_W-1:0]   sphere_radius = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic hit;
    logic [Q_W-1:0] distance;

    isect_t expected_isects[$];
    int     n_errors = 0;
    int     cycle_count = 0;
    int     sender_idle_pct = 38;
    int     receiver_idle_pct = 38;
    int     hold_off_cycles = 0;

    ray_sphere_intersect_unit dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Integer square root of a non-negative value, bit by bit.
    function automatic logic [95:0] isqrt96(logic [191:0] n);
        logic [95:0]  root;
        logic [95:0]  cand;
        root = '0;
        for (int b = 95; b >= 0; b--)
        begin
            cand = root;
            cand[b] = 1'b1;
            if (192'(cand) * 192'(cand) <= n)
                root = cand;
        end
        return root;
    endfunction

    function automatic isect_t predict_isect(ray_t ray);
        isect_t res;
        logic signed [191:0] a, h, c, disc, o, d, rad, num, t;
        logic signed [COORD_W-1:0] oc[3], dc[3], cc[3];
        oc = '{ray.ox, ray.oy, ray.oz};
        dc = '{ray.dx, ray.dy, ray.dz};
        cc = '{ray.cx, ray.cy, ray.cz};
        a = 0; h = 0; c = 0;
        for (int i = 0; i < 3; i++)
        begin
            o = 192'(oc[i]) - 192'(cc[i]);
            d = 192'(dc[i]);
            a += d * d;
            h += o * d;
            c += o * o;
        end
        rad = 192'({1'b0, ray.r});
        c -= rad * rad;
        disc = h * h - a * c;
        res.hit = 1'b0;
        res.t_near = '0;
        if (a != 0 && h < 0 && c > 0 && disc > 0)
        begin
            num = (-h - 192'(isqrt96(disc))) <<< FRAC_BITS;
            t = num / a;
            res.hit = 1'b1;
            res.t_near = (t >= 192'h1_0000_0000) ? '1 : t[Q_W-1:0];
        end
        return res;
    endfunction

    // Drives one beat and holds it until accepted; valid drops only while the sender idles.
    task automatic send_ray(ray_t ray);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            ray_valid <= 1'b0;
            @(posedge clk);
        end
        ray_valid     <= 1'b1;
        origin_x      <= ray.ox; origin_y <= ray.oy; origin_z <= ray.oz;
        dir_x         <= ray.dx; dir_y    <= ray.dy; dir_z    <= ray.dz;
        center_x      <= ray.cx; center_y <= ray.cy; center_z <= ray.cz;
        sphere_radius <= ray.r;
        expected_isects.push_back(predict_isect(ray));
        do
            @(posedge clk);
        while (ray_stall);
    endtask

    function automatic logic [COORD_W-1:0] rnd_coord();
        case ($urandom_range(3))
            0: return COORD_W'($urandom);
            1: return COORD_W'($urandom_range(0, 2048) - 1024);
            2: return COORD_W'($urandom_range(0, 64) - 32);
            default: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        endcase
    endfunction

    // Mostly a sphere placed along the ray so that hits are common.
    function automatic ray_t rnd_ray();
        ray_t ray;
        int   k;
        ray.ox = rnd_coord(); ray.oy = rnd_coord(); ray.oz = rnd_coord();
        ray.dx = rnd_coord(); ray.dy = rnd_coord(); ray.dz = rnd_coord();
        ray.r  = RAD_W'($urandom);
        if ($urandom_range(99) < 60)
        begin
            ray.dx = COORD_W'($urandom_range(0, 512) - 256);
            ray.dy = COORD_W'($urandom_range(0, 512) - 256);
            ray.dz = COORD_W'($urandom_range(0, 512) - 256);
            k = $urandom_range(1, 60);
            ray.cx = ray.ox + COORD_W'(k * $signed(ray.dx) + $urandom_range(0, 200) - 100);
            ray.cy = ray.oy + COORD_W'(k * $signed(ray.dy) + $urandom_range(0, 200) - 100);
            ray.cz = ray.oz + COORD_W'(k * $signed(ray.dz));
            ray.r  = RAD_W'($urandom_range(1, 3000));
        end
        else
        begin
            ray.cx = rnd_coord(); ray.cy = rnd_coord(); ray.cz = rnd_coord();
        end
        return ray;
    endfunction

    function automatic ray_t mk_ray(int ox, oy, oz, dx, dy, dz, cx, cy, cz, r);
        ray_t ray;
        ray.ox = COORD_W'(ox); ray.oy = COORD_W'(oy); ray.oz = COORD_W'(oz);
        ray.dx = COORD_W'(dx); ray.dy = COORD_W'(dy); ray.dz = COORD_W'(dz);
        ray.cx = COORD_W'(cx); ray.cy = COORD_W'(cy); ray.cz = COORD_W'(cz);
        ray.r  = RAD_W'(r);
        return ray;
    endfunction

    task automatic test_special_cases();
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, 2560, 0, 0, 256));       // zero direction
        send_ray(mk_ray(0, 0, 0, 256, 0, 0, 2560, 0, 0, 256));     // plain hit
        send_ray(mk_ray(0, 0, 0, 256, 0, 0, 0, 0, 0, 256));        // origin inside
        send_ray(mk_ray(256, 0, 0, 256, 0, 0, 0, 0, 0, 256));      // origin on surface
        send_ray(mk_ray(0, 0, 0, -256, 0, 0, 2560, 0, 0, 256));    // sphere behind
        send_ray(mk_ray(0, 0, 0, 256, 0, 0, 2560, 256, 0, 256));   // tangent
        send_ray(mk_ray(0, 0, 0, 256, 0, 0, 2560, 512, 0, 256));   // clean miss
        send_ray(mk_ray(0, 0, 0, 32767, 0, 0, 300, 0, 0, 40));     // distance below one coordinate unit
        send_ray(mk_ray(-32768, 0, 0, 1, 0, 0, 32767, 0, 0, 1));   // far hit, distance 65534
        send_ray(mk_ray(-32768, -32768, -32768, 32767, 32767, 32767,
                        32767, 32767, 32767, 32767));
        send_ray(mk_ray(32767, 32767, 32767, -32768, -32768, -32768,
                        -32768, -32768, -32768, 32767));
        send_ray(mk_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0));
        send_ray(mk_ray(32767, -32768, 0, -32768, 32767, 0, -32768, 32767, 0, 0));
        send_ray(mk_ray(0, 0, 0, 0, 0, 256, 0, 0, 32767, 32767));
    endtask

    task automatic test_random_stream(int n_rays);
        for (int i = 0; i < n_rays; i++)
        begin
            // A stretch without idling in the middle of the stream.
            sender_idle_pct   = (i >= n_rays / 3 && i < n_rays / 2) ? 0 : 38;
            receiver_idle_pct = sender_idle_pct;
            send_ray(rnd_ray());
        end
    endtask

    // The receiver holds off long enough to fill the pipeline and stall the input.
    task automatic test_back_pressure();
        hold_off_cycles = 3 * LATENCY;
        sender_idle_pct = 0;
        for (int i = 0; i < 150; i++)
            send_ray(rnd_ray());
        sender_idle_pct = 38;
    endtask

    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            res_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            res_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        isect_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_isects.size() == 0)
            begin
                $error("result beat with no ray outstanding");
                n_errors++;
            end
            else
            begin
                want = expected_isects.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, hit);
                    n_errors++;
                end
                if (distance !== want.t_near)
                begin
                    $error("distance: expected %0h, actual %0h", want.t_near, distance);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_random_stream(1550);
        test_back_pressure();
        ray_valid <= 1'b0;
        wait (expected_isects.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
src/rsi_pkg.sv
src/rsi_front.sv
src/rsi_sqrt_cell.sv
src/rsi_div_cell.sv
src/ray_sphere_intersect_unit.sv
sim/ray_sphere_intersect_unit_tb.sv
